>>> rtl/core/svc_pkg.sv
package svc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SumW  = 64;
  localparam int unsigned RootW = 32;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegMuOffset = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSmagGain = 1'b1;

  localparam logic [DataW-1:0] MuOffsetRst = 32'd3277;
  localparam logic [DataW-1:0] SmagGainRst = 32'd32768;

  // Sum of squares and scaled gain on their way into the square root.
  typedef struct packed {
    logic            valid;
    logic [SumW-1:0] sum;
    logic [SumW-1:0] gain_area;
  } sq_in_t;

  // Root and scaled gain on their way into the output scaling.
  typedef struct packed {
    logic             valid;
    logic [RootW-1:0] root;
    logic [SumW-1:0]  gain_area;
  } sq_out_t;

  // Magnitude of a two's complement word; the most negative value gives 2^31.
  function automatic logic [DataW-1:0] mag(input logic [DataW-1:0] v);
    logic [DataW-1:0] r;
    r = v[DataW-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

>>> rtl/core/svc_if.sv
interface svc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] mesh_area;
  logic [31:0] du_dx;
  logic [31:0] du_dy;
  logic [31:0] dv_dx;
  logic [31:0] dv_dy;
  modport source (output valid, mesh_area, du_dx, du_dy, dv_dx, dv_dy, input ready);
  modport sink   (input valid, mesh_area, du_dx, du_dy, dv_dx, dv_dy, output ready);
endinterface

interface svc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] viscosity;
  modport source (output valid, viscosity, input ready);
  modport sink   (input valid, viscosity, output ready);
endinterface

>>> rtl/core/smagorinsky_viscosity_coefficient_unit.sv
// Channel  | Direction | Fields
// in_i     | sink      | mesh_area, du_dx, du_dy, dv_dx, dv_dy
// out_o    | source    | viscosity
// cfg      | write     | cfg_we_i, cfg_idx_i, cfg_data_i
//
// One cell enters per cycle unless stalled; its result passes three stages of
// magnitudes, squares and sum, 32 square-root stages (one root bit each), three
// stages of scaling and offset. Reset clears valid bits and restores registers.
// A stall at the output freezes the whole pipeline, so nothing is lost or repeated.
module smagorinsky_viscosity_coefficient_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  svc_in_if.sink                          in_i,
  svc_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [svc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [svc_pkg::DataW-1:0]       cfg_data_i
);

  logic             en;
  logic [31:0]      mu_offset_q, smag_gain_q;
  svc_pkg::sq_in_t  sq_in;
  svc_pkg::sq_out_t sq_out;

  // The pipeline advances whenever the output register is free or drained.
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_offset_q <= svc_pkg::MuOffsetRst;
      smag_gain_q <= svc_pkg::SmagGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        svc_pkg::RegMuOffset: mu_offset_q <= cfg_data_i;
        svc_pkg::RegSmagGain: smag_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  svc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_i.valid),
    .mesh_area_i (in_i.mesh_area),
    .du_dx_i     (in_i.du_dx),
    .du_dy_i     (in_i.du_dy),
    .dv_dx_i     (in_i.dv_dx),
    .dv_dy_i     (in_i.dv_dy),
    .smag_gain_i (smag_gain_q),
    .sq_o        (sq_in)
  );

  svc_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .sq_i   (sq_in),
    .sq_o   (sq_out)
  );

  svc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .sq_i        (sq_out),
    .mu_offset_i (mu_offset_q),
    .valid_o     (out_o.valid),
    .viscosity_o (out_o.viscosity)
  );

endmodule

>>> rtl/core/svc_front.sv
module svc_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [31:0]         mesh_area_i,
  input  logic [31:0]         du_dx_i,
  input  logic [31:0]         du_dy_i,
  input  logic [31:0]         dv_dx_i,
  input  logic [31:0]         dv_dy_i,
  input  logic [31:0]         smag_gain_i,
  output svc_pkg::sq_in_t     sq_o
);

  logic        v1_q, v2_q, v3_q;
  logic [31:0] ax_q, ay_q;
  logic [32:0] s_q;
  logic [63:0] ga1_q, ga2_q, ga3_q;
  logic [63:0] ax2_q, ay2_q;
  logic [65:0] ss_q;
  logic [63:0] sum_q;
  logic [63:0] ga_prod;
  logic [65:0] sum_full;

  // Gain times area, scaled back to the fixed-point format.
  assign ga_prod  = 64'(smag_gain_i) * 64'(mesh_area_i);
  assign sum_full = 66'(ax2_q) + 66'(ay2_q) + (ss_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage one: magnitudes; stage two: squares; stage three: saturating sum.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q  <= svc_pkg::mag(du_dx_i);
      ay_q  <= svc_pkg::mag(dv_dy_i);
      s_q   <= 33'(svc_pkg::mag(du_dy_i)) + 33'(svc_pkg::mag(dv_dx_i));
      ga1_q <= ga_prod >> FRAC_BITS;
      ax2_q <= 64'(ax_q) * 64'(ax_q);
      ay2_q <= 64'(ay_q) * 64'(ay_q);
      ss_q  <= 66'(s_q) * 66'(s_q);
      ga2_q <= ga1_q;
      sum_q <= (sum_full[65:64] != 2'b00) ? {64{1'b1}} : sum_full[63:0];
      ga3_q <= ga2_q;
    end
  end

  assign sq_o.valid     = v3_q;
  assign sq_o.sum       = sum_q;
  assign sq_o.gain_area = ga3_q;

endmodule

>>> rtl/core/svc_sqrt.sv
module svc_sqrt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  svc_pkg::sq_in_t  sq_i,
  output svc_pkg::sq_out_t sq_o
);

  localparam int unsigned Steps = svc_pkg::RootW;

  // Per-stage state: one root bit is settled in each stage.
  logic              v_q   [Steps];
  logic [34:0]       rem_q [Steps];
  logic [31:0]       root_q[Steps];
  logic [63:0]       x_q   [Steps];
  logic [63:0]       ga_q  [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic        v_in;
    logic [34:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] x_in;
    logic [63:0] ga_in;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        take;

    if (i == 0) begin : g_first
      assign v_in    = sq_i.valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = sq_i.sum;
      assign ga_in   = sq_i.gain_area;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign x_in    = x_q[i-1];
      assign ga_in   = ga_q[i-1];
    end

    // Bring down the next two bits and try to subtract 4*root+1.
    assign rem_sh = {rem_in[32:0], x_in[63:62]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[i] <= {root_in[30:0], take};
        x_q[i]    <= {x_in[61:0], 2'b00};
        ga_q[i]   <= ga_in;
      end
    end
  end

  assign sq_o.valid     = v_q[Steps-1];
  assign sq_o.root      = root_q[Steps-1];
  assign sq_o.gain_area = ga_q[Steps-1];

endmodule

>>> rtl/core/svc_scale.sv
module svc_scale #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  svc_pkg::sq_out_t sq_i,
  input  logic [31:0]      mu_offset_i,
  output logic             valid_o,
  output logic [31:0]      viscosity_o
);

  logic        v1_q, v2_q, v3_q;
  logic [63:0] lo_q, hi_q;
  logic        sat_q;
  logic [31:0] q_q;
  logic [31:0] res_q;
  logic [95:0] prod;
  logic [32:0] res_sum;

  // Full product of scaled gain and root, from two partial products.
  assign prod    = {hi_q, 32'd0} + 96'(lo_q);
  assign res_sum = 33'(mu_offset_i) + 33'(q_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= sq_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q  <= 64'(sq_i.gain_area[31:0]) * 64'(sq_i.root);
      hi_q  <= 64'(sq_i.gain_area[63:32]) * 64'(sq_i.root);
      // Anything at or above 2^(32+FRAC_BITS) leaves the output range.
      sat_q <= ((prod >> (32 + FRAC_BITS)) != 96'd0);
      q_q   <= prod[FRAC_BITS +: 32];
      res_q <= (sat_q || res_sum[32]) ? 32'hFFFF_FFFF : res_sum[31:0];
    end
  end

  assign valid_o     = v3_q;
  assign viscosity_o = res_q;

endmodule

>>> bench/smagorinsky_viscosity_coefficient_unit_tb.sv
`timescale 1ns / 100ps

module smagorinsky_viscosity_coefficient_unit_tb;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned DrainCyc  = 60;
  localparam int unsigned StallLimit = 5000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [svc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [svc_pkg::DataW-1:0] cfg_data_i;

  svc_in_if  in_if ();
  svc_out_if out_if ();

  smagorinsky_viscosity_coefficient_unit #(
    .FRAC_BITS(FracBits)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the configuration registers.
  logic [svc_pkg::DataW-1:0] offset_reg;
  logic [svc_pkg::DataW-1:0] gain_reg;

  logic [svc_pkg::DataW-1:0] viscosity_q[$];
  int unsigned mismatch_cnt;
  int unsigned idle_cycles;
  bit          sender_idles;
  bit          sink_stalls;
  int unsigned stall_left;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Magnitude of a two's complement word, widened so that 2^31 fits.
  function automatic logic [32:0] magnitude(input logic [31:0] v);
    logic [32:0] r;
    r = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    return r;
  endfunction

  // Floor of the square root of a 64-bit value.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = x;
    res  = '0;
    bitv = 64'h1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Expected viscosity of one cell under the current register settings.
  function automatic logic [31:0] predict_viscosity(input logic [31:0] area,
                                                    input logic [31:0] ux,
                                                    input logic [31:0] uy,
                                                    input logic [31:0] vx,
                                                    input logic [31:0] vy);
    logic [65:0]  ax;
    logic [65:0]  ay;
    logic [65:0]  cross_sum;
    logic [65:0]  total;
    logic [63:0]  strain;
    logic [63:0]  root;
    logic [63:0]  scaled_gain;
    logic [127:0] prod;
    logic [127:0] q;
    logic [32:0]  r;
    ax    = {33'b0, magnitude(ux)};
    ay    = {33'b0, magnitude(vy)};
    cross_sum = {33'b0, magnitude(uy)} + {33'b0, magnitude(vx)};
    total = ax * ax + ay * ay + ((cross_sum * cross_sum) >> 1);
    strain = (total > 66'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : total[63:0];
    root = floor_sqrt(strain);
    scaled_gain = ({32'b0, gain_reg} * {32'b0, area}) >> FracBits;
    prod = {64'b0, scaled_gain} * {64'b0, root};
    if (prod[127:64] != 0) return 32'hFFFF_FFFF;
    q = prod >> FracBits;
    if (q > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
    r = {1'b0, offset_reg} + q[32:0];
    return r[32] ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  // Random word that favors extremes and moderate magnitudes.
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 7))
      0, 1: w = $urandom();
      2: w = $urandom_range(0, 32'h0004_0000);
      3: w = $urandom_range(0, 32'h0100_0000);
      4: w = 32'h8000_0000;
      5: w = 32'h7FFF_FFFF;
      6: w = $urandom_range(0, 2);
      default: w = $urandom_range(0, 32'h0010_0000);
    endcase
    if ($urandom_range(0, 1) && w != 32'h8000_0000) w = -w;
    return w;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned g;
    if (!sender_idles) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: g = 0;
      6, 7, 8: g = $urandom_range(1, 3);
      default: g = $urandom_range(4, 40);
    endcase
    return g;
  endfunction

  // Send one cell and record its expected viscosity on acceptance.
  task automatic send_cell(input logic [31:0] area, input logic [31:0] ux,
                           input logic [31:0] uy, input logic [31:0] vx,
                           input logic [31:0] vy);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.mesh_area = area;
    in_if.du_dx = ux;
    in_if.du_dy = uy;
    in_if.dv_dx = vx;
    in_if.dv_dy = vy;
    in_if.valid = 1'b1;
    forever begin
      @(posedge clk_i);
      if (in_if.ready) break;
    end
    viscosity_q.push_back(predict_viscosity(area, ux, uy, vx, vy));
    @(negedge clk_i);
  endtask

  // Let the pipeline empty so that a register write cannot touch a cell in flight.
  task automatic drain();
    in_if.valid = 1'b0;
    while (viscosity_q.size() != 0) @(negedge clk_i);
    repeat (DrainCyc) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [svc_pkg::CfgIdxW-1:0] idx,
                           input logic [svc_pkg::DataW-1:0] data);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == svc_pkg::RegMuOffset) offset_reg = data;
    else if (idx == svc_pkg::RegSmagGain) gain_reg = data;
  endtask

  // Extremes of every field under reset register values, then extreme and unity-gain settings.
  task automatic test_directed();
    sender_idles = 1'b0;
    sink_stalls = 1'b0;
    send_cell(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_cell(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cell(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_cell(32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_cell(32'h0000_0001, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
    send_cell(32'h0002_0000, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0003_0000);
    send_cell(32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
    write_reg(svc_pkg::RegMuOffset, 32'hFFFF_FFFF);
    write_reg(svc_pkg::RegSmagGain, 32'hFFFF_FFFF);
    send_cell(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_cell(32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0, 32'h0);
    send_cell(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    write_reg(svc_pkg::RegMuOffset, 32'h0);
    write_reg(svc_pkg::RegSmagGain, 32'h0);
    send_cell(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    write_reg(svc_pkg::RegSmagGain, 32'h0001_0000);
    send_cell(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_cell(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0);
    send_cell(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_cell(32'h0100_0000, 32'h0100_0000, 32'h0, 32'h0, 32'h0);
    send_cell(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
  endtask

  // One random phase under a given register setting.
  task automatic test_random(input logic [svc_pkg::DataW-1:0] offset,
                             input logic [svc_pkg::DataW-1:0] gain,
                             input int unsigned cells);
    write_reg(svc_pkg::RegMuOffset, offset);
    write_reg(svc_pkg::RegSmagGain, gain);
    for (int unsigned i = 0; i < cells; i++) begin
      if (i % 100 == 0) begin
        sender_idles = $urandom_range(0, 3) != 0;
        sink_stalls = $urandom_range(0, 3) != 0;
      end
      send_cell(pick_word() & 32'h7FFF_FFFF | ($urandom_range(0, 1) << 31),
                pick_word(), pick_word(), pick_word(), pick_word());
    end
  endtask

  // Output readiness: when sink_stalls is set, mostly short stalls, now and then a long one.
  always @(negedge clk_i) begin
    if (!sink_stalls) begin
      out_if.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          stall_left <= $urandom_range(5, 40);
          out_if.ready <= 1'b0;
        end
        1, 2, 3: out_if.ready <= 1'b0;
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  // Compare each output transaction with the oldest expected viscosity.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (viscosity_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("ERROR: unexpected viscosity %h", out_if.viscosity);
      end else begin
        if (out_if.viscosity !== viscosity_q[0]) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: viscosity expected %h actual %h",
                     viscosity_q[0], out_if.viscosity);
        end
        void'(viscosity_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAIL smagorinsky_viscosity_coefficient_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = svc_pkg::RegMuOffset;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.mesh_area = '0;
    in_if.du_dx = '0;
    in_if.du_dy = '0;
    in_if.dv_dx = '0;
    in_if.dv_dy = '0;
    out_if.ready = 1'b1;
    offset_reg = svc_pkg::MuOffsetRst;
    gain_reg = svc_pkg::SmagGainRst;
    mismatch_cnt = 0;
    idle_cycles = 0;
    stall_left = 0;
    sender_idles = 1'b0;
    sink_stalls = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(svc_pkg::MuOffsetRst, svc_pkg::SmagGainRst, 350);
    test_random(32'h0, 32'h0001_0000, 350);
    test_random(32'hFFFF_FFFF, 32'hFFFF_FFFF, 300);
    test_random($urandom(), $urandom_range(0, 32'h0004_0000), 350);
    test_random($urandom_range(0, 32'h0010_0000), 32'h0, 100);
    test_random(32'h0000_0001, $urandom(), 300);

    drain();
    if (mismatch_cnt == 0) begin
      $display("PASS smagorinsky_viscosity_coefficient_unit");
    end else begin
      $display("FAIL smagorinsky_viscosity_coefficient_unit");
    end
    $finish;
  end

endmodule
